@@ hw/rtl/convex_quad_overlap_sat_macros.svh @@
// assertion helpers used by cqo_back
`ifndef CONVEX_QUAD_OVERLAP_SAT_MACROS_SVH
`define CONVEX_QUAD_OVERLAP_SAT_MACROS_SVH

// same-cycle implication
`define CQO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CQO_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cqo_pkg.sv @@
`default_nettype none
package cqo_pkg;

  localparam int COORD_BITS = 16;
  localparam int AXIS_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = COORD_BITS + AXIS_BITS;
  localparam int PROJ_BITS  = PROD_BITS + 1;

  typedef struct packed {
    logic                         last;
    logic                         store_en;
    logic                         poly;
    logic [1:0]                   vidx;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } item_t;

endpackage
`default_nettype wire

@@ hw/rtl/convex_quad_overlap_sat.sv @@
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    polygon, vertex_index, vertex_x, vertex_y, last
// out      output     out_valid/out_ready  collided
//
// a vertex item is taken every cycle while the queue has room and the test engine is idle
// a last item starts a test of 2*VERTS axes, each projected on one
// projection unit (two store read ports, two multipliers)
// the test stops at the first separating axis
// rst is synchronous; vertex store contents are not cleared
// a stalled result holds the engine from starting the next test
`default_nettype none
module convex_quad_overlap_sat #(
  parameter int VERTS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  polygon,
  input  logic [1:0]                            vertex_index,
  input  logic signed [cqo_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [cqo_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  collided
);
  import cqo_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  cqo_front #(.VERTS(VERTS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .polygon      (polygon),
    .vertex_index (vertex_index),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .last         (last),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  cqo_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  cqo_back #(.VERTS(VERTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .collided  (collided)
  );

endmodule
`default_nettype wire

@@ hw/rtl/cqo_front.sv @@
`default_nettype none
module cqo_front #(
  parameter int VERTS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  polygon,
  input  logic [1:0]                            vertex_index,
  input  logic signed [cqo_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [cqo_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                  last,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output cqo_pkg::item_t                        push_item
);
  import cqo_pkg::*;

  logic  hold_vld;
  item_t hold;

  assign in_ready   = !hold_vld || push_ready;
  assign push_valid = hold_vld;
  assign push_item  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_vld <= 1'b1;
    end else if (push_ready) begin
      hold_vld <= 1'b0;
    end
  end

  // classify: out-of-range vertex slots are dropped but the item still counts
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold.last     <= last;
      hold.store_en <= (int'(vertex_index) < VERTS);
      hold.poly     <= polygon;
      hold.vidx     <= vertex_index;
      hold.x        <= vertex_x;
      hold.y        <= vertex_y;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cqo_queue.sv @@
`default_nettype none
module cqo_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  cqo_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output cqo_pkg::item_t rd_item
);
  import cqo_pkg::*;

  item_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_item;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cqo_back.sv @@
`default_nettype none
`include "convex_quad_overlap_sat_macros.svh"
module cqo_back #(
  parameter int VERTS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  cqo_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           collided
);
  import cqo_pkg::*;

  localparam int AW = $clog2(2 * VERTS);
  localparam int VW = $clog2(VERTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AXIS_RD,
    S_AXIS_CALC,
    S_PROJ,
    S_DRAIN,
    S_CHECK
  } state_t;

  state_t state;

  logic signed [COORD_BITS-1:0] store_x [2*VERTS];
  logic signed [COORD_BITS-1:0] store_y [2*VERTS];

  logic [AW-1:0]                waddr;
  logic [AW-1:0]                ra0;
  logic [AW-1:0]                ra1;
  logic [AW-1:0]                base;
  logic [VW-1:0]                b_idx;
  logic signed [COORD_BITS-1:0] rd0_x;
  logic signed [COORD_BITS-1:0] rd0_y;
  logic signed [COORD_BITS-1:0] rd1_x;
  logic signed [COORD_BITS-1:0] rd1_y;

  logic                         side;
  logic [VW-1:0]                a_idx;
  logic [AW-1:0]                k;
  logic signed [AXIS_BITS-1:0]  ax;
  logic signed [AXIS_BITS-1:0]  ay;
  logic                         p1_vld;
  logic                         p1_poly;
  logic                         p1_first;
  logic                         p2_vld;
  logic                         p2_poly;
  logic                         p2_first;
  logic signed [PROD_BITS-1:0]  px;
  logic signed [PROD_BITS-1:0]  py;
  logic signed [PROJ_BITS-1:0]  p_sum;
  logic signed [PROJ_BITS-1:0]  mn [2];
  logic signed [PROJ_BITS-1:0]  mx [2];
  logic                         sep;
  logic                         pop;

  assign q_ready = (state == S_IDLE) && (!q_item.last || !out_valid);
  assign pop     = q_valid && q_ready;

  assign waddr = q_item.poly ? AW'(VERTS) + AW'(q_item.vidx) : AW'(q_item.vidx);
  assign base  = side ? AW'(VERTS) : '0;
  assign b_idx = (a_idx == VW'(VERTS - 1)) ? '0 : a_idx + 1'b1;
  assign ra0   = (state == S_AXIS_RD) ? base + AW'(a_idx) : k;
  assign ra1   = base + AW'(b_idx);
  assign p_sum = PROJ_BITS'(px) + PROJ_BITS'(py);
  assign sep   = !((mx[1] >= mn[0]) && (mx[0] >= mn[1]));

  always_ff @(posedge clk) begin
    if (pop && q_item.store_en) begin
      store_x[waddr] <= q_item.x;
      store_y[waddr] <= q_item.y;
    end
    rd0_x <= store_x[ra0];
    rd0_y <= store_y[ra0];
    rd1_x <= store_x[ra1];
    rd1_y <= store_y[ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // projection pipe: read, multiply, sum and fold into the interval
      p1_vld <= (state == S_PROJ);
      p2_vld <= p1_vld;
      if (p2_vld) begin
        if (p2_first) begin
          mn[p2_poly] <= p_sum;
          mx[p2_poly] <= p_sum;
        end else begin
          if (p_sum < mn[p2_poly]) begin
            mn[p2_poly] <= p_sum;
          end
          if (p_sum > mx[p2_poly]) begin
            mx[p2_poly] <= p_sum;
          end
        end
      end

      unique case (state)
        S_IDLE: begin
          if (pop && q_item.last) begin
            side  <= 1'b0;
            a_idx <= '0;
            state <= S_AXIS_RD;
          end
        end
        S_AXIS_RD: begin
          state <= S_AXIS_CALC;
        end
        S_AXIS_CALC: begin
          // edge normal, not normalized
          ax    <= AXIS_BITS'(rd0_y) - AXIS_BITS'(rd1_y);
          ay    <= AXIS_BITS'(rd1_x) - AXIS_BITS'(rd0_x);
          k     <= '0;
          state <= S_PROJ;
        end
        S_PROJ: begin
          k <= k + 1'b1;
          if (k == AW'(2 * VERTS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!p1_vld && !p2_vld) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sep) begin
            out_valid <= 1'b1;
            collided  <= 1'b0;
            state     <= S_IDLE;
          end else if (side && (a_idx == VW'(VERTS - 1))) begin
            out_valid <= 1'b1;
            collided  <= 1'b1;
            state     <= S_IDLE;
          end else begin
            if (a_idx == VW'(VERTS - 1)) begin
              a_idx <= '0;
              side  <= 1'b1;
            end else begin
              a_idx <= a_idx + 1'b1;
            end
            state <= S_AXIS_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p1_poly  <= (k >= AW'(VERTS));
    p1_first <= (k == '0) || (k == AW'(VERTS));
    p2_poly  <= p1_poly;
    p2_first <= p1_first;
    px       <= PROD_BITS'(rd0_x) * PROD_BITS'(ax);
    py       <= PROD_BITS'(rd0_y) * PROD_BITS'(ay);
  end

  `CQO_ASSERT_IMP(a_no_pop_busy, clk, rst, state != S_IDLE, !q_ready, "queue popped during a test")
  `CQO_ASSERT_IMP(a_last_out_free, clk, rst, pop && q_item.last, !out_valid, "test started with result pending")
  `CQO_ASSERT_NXT(a_result_src, clk, rst, !out_valid && state != S_CHECK, !out_valid, "result without check")
  `CQO_ASSERT_IMP(a_pipe_idle, clk, rst, state == S_IDLE, !p1_vld && !p2_vld, "projection pipe busy in idle")

endmodule
`default_nettype wire
